// File: rtl/scba_pkg.sv
package scba_pkg;

    // grain address width of the request and response words
    localparam int unsigned ADDR_W = 12;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_RELEASE = 3'd2,
        OP_QSIZE   = 3'd3,
        OP_QALLOC  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_SPACE  = 2'd1,
        STS_NOT_ALLOC = 2'd2
    } t_status;

    // result of a find-first-set search
    typedef struct packed {
        logic        found;
        logic [15:0] idx;
    } t_ffs;

endpackage

// File: rtl/scba_if.sv
// request word channel
interface scba_req_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  opcode;
    logic [2:0]                  size_log2;
    logic [scba_pkg::ADDR_W-1:0] block_addr;

    modport source (output valid, output opcode, output size_log2, output block_addr,
                    input ready);
    modport sink   (input valid, input opcode, input size_log2, input block_addr,
                    output ready);
endinterface

// response word channel
interface scba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [scba_pkg::ADDR_W-1:0] result_addr;
    logic [2:0]                  block_size_log2;
    logic                        is_allocated;

    modport source (output valid, output status, output result_addr,
                    output block_size_log2, output is_allocated, input ready);
    modport sink   (input valid, input status, input result_addr,
                    input block_size_log2, input is_allocated, output ready);
endinterface

// File: rtl/scba_ffs.sv
// lowest set bit of a vector
module scba_ffs #(
    parameter int unsigned WIDTH = 64
) (
    input  logic [WIDTH-1:0] i_vec,
    output scba_pkg::t_ffs   o_res
);
    always_comb begin
        o_res = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_res.found = 1'b1;
                o_res.idx   = 16'(i);
            end
        end
    end
endmodule

// File: rtl/scba_ram.sv
// single-port-write, registered-read record memory
module scba_ram #(
    parameter int unsigned DW    = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/size_class_bitmap_allocator.sv
// Flow: a request word is taken as its record is read from the unit record memories; once the
// output register is free, the record is modified and written back as the response word is registered.
// A response waits in an output register; the next request is taken meanwhile.
// Reset: synchronous; afterwards a clearing pass writes the empty record into every unit
// in turn, and no request is taken until it ends.
module size_class_bitmap_allocator #(
    parameter int unsigned NUM_UNITS        = 64,
    parameter int unsigned UNIT_GRAINS_LOG2 = 6
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    scba_req_if.sink   i_req,
    scba_rsp_if.source o_rsp
);
    localparam int unsigned G     = UNIT_GRAINS_LOG2;
    localparam int unsigned SLOTS = 1 << G;
    localparam int unsigned UW    = $clog2(NUM_UNITS);
    localparam int unsigned CW    = $clog2(G + 1);
    localparam int unsigned NW    = G + 1;
    localparam int unsigned AW    = scba_pkg::ADDR_W;

    typedef struct packed {
        logic [SLOTS-1:0] bits;
        logic [CW-1:0]    cls;
        logic [NW-1:0]    fr;
        logic [NW-1:0]    tot;
    } t_rec;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} t_state;

    localparam logic [CW-1:0] EMPTY = CW'(G);

    t_state                r_state;
    logic [UW-1:0]         r_clr;
    scba_pkg::t_op         r_op;
    logic [CW-1:0]         r_cls;
    logic [AW-1:0]         r_addr;
    logic [UW-1:0]         r_unit;
    logic                  r_found;
    logic                  r_inrange;
    logic [NUM_UNITS-1:0]  r_map [G+1];
    logic [NUM_UNITS-1:0]  n_map [G+1];
    logic                  r_rsp_valid;
    logic [1:0]            r_sts;
    logic [AW-1:0]         r_raddr;
    logic [2:0]            r_qsize;
    logic                  r_qalloc;

    // request decode
    logic                  acc;
    logic [CW-1:0]         c_in;
    logic [AW-1:0]         unit_full;
    logic [UW-1:0]         rd_unit;
    scba_pkg::t_ffs        ffs_c;
    scba_pkg::t_ffs        ffs_e;

    assign i_req.ready = (r_state == ST_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign c_in        = (4'(i_req.size_log2) > 4'(G)) ? EMPTY : CW'(i_req.size_log2);
    assign unit_full   = i_req.block_addr >> G;

    scba_ffs #(.WIDTH(NUM_UNITS)) u_ffs_class (.i_vec(r_map[c_in]), .o_res(ffs_c));
    scba_ffs #(.WIDTH(NUM_UNITS)) u_ffs_empty (.i_vec(r_map[G]),    .o_res(ffs_e));

    always_comb begin
        if (scba_pkg::t_op'(i_req.opcode) == scba_pkg::OP_ALLOC) begin
            rd_unit = ffs_c.found ? UW'(ffs_c.idx) : UW'(ffs_e.idx);
        end else begin
            rd_unit = UW'(unit_full);
        end
    end

    // record memories
    t_rec lrec, crec, n_lrec, n_crec, rst_rec, lw_data, cw_data;
    logic lwe, cwe, go, clearing;
    logic [UW-1:0] waddr;
    logic [$bits(t_rec)-1:0] l_rd, c_rd;

    assign rst_rec  = '{bits: '0, cls: EMPTY, fr: NW'(1), tot: NW'(1)};
    assign clearing = (r_state == ST_CLEAR);
    assign go       = (r_state == ST_EXEC) && (!r_rsp_valid || o_rsp.ready);
    assign waddr    = clearing ? r_clr : r_unit;
    assign lw_data  = clearing ? rst_rec : n_lrec;
    assign cw_data  = clearing ? rst_rec : n_crec;
    assign lrec     = t_rec'(l_rd);
    assign crec     = t_rec'(c_rd);

    scba_ram #(.DW($bits(t_rec)), .DEPTH(NUM_UNITS)) u_lock_mem (
        .i_clk(i_clk), .i_we(clearing || (go && lwe)), .i_waddr(waddr),
        .i_wdata(lw_data), .i_re(acc), .i_raddr(rd_unit), .o_rdata(l_rd)
    );
    scba_ram #(.DW($bits(t_rec)), .DEPTH(NUM_UNITS)) u_comm_mem (
        .i_clk(i_clk), .i_we(clearing || (go && cwe)), .i_waddr(waddr),
        .i_wdata(cw_data), .i_re(acc), .i_raddr(rd_unit), .o_rdata(c_rd)
    );

    // first free slot of the lock record
    logic [SLOTS-1:0] avail;
    scba_pkg::t_ffs   ffs_s;
    logic [NW-1:0]    lim;

    always_comb begin
        lim = (lrec.tot > NW'(SLOTS)) ? NW'(SLOTS) : lrec.tot;
        for (int i = 0; i < SLOTS; i++) begin
            avail[i] = !lrec.bits[i] && (NW'(i) < lim);
        end
    end

    scba_ffs #(.WIDTH(SLOTS)) u_ffs_slot (.i_vec(avail), .o_res(ffs_s));

    // modify step
    t_rec          frec;
    logic [CW-1:0] fc;
    logic [G-1:0]  fbit;
    logic [G-1:0]  abit;
    logic [NW-1:0] ffr;
    logic [CW-1:0] qc;
    logic [1:0]    sts;
    logic [AW-1:0] raddr;
    logic [2:0]    qsize;
    logic          qalloc;
    logic          lock_side;

    always_comb begin
        n_lrec    = lrec;
        n_crec    = crec;
        lwe       = 1'b0;
        cwe       = 1'b0;
        n_map     = r_map;
        sts       = scba_pkg::STS_OK;
        raddr     = '0;
        qsize     = '0;
        qalloc    = 1'b0;
        abit      = '0;
        lock_side = (r_op == scba_pkg::OP_RELEASE);
        frec      = lock_side ? lrec : crec;
        fc        = (frec.cls > EMPTY) ? EMPTY : frec.cls;
        fbit      = r_addr[G-1:0] >> fc;
        ffr       = frec.fr + NW'(1);
        qc        = (crec.cls > EMPTY) ? EMPTY : crec.cls;

        case (r_op)
            scba_pkg::OP_ALLOC: begin
                if (!r_found) begin
                    sts = scba_pkg::STS_NO_SPACE;
                end else if (lrec.cls == EMPTY && lrec.fr != '0) begin
                    // claim an empty unit for this class
                    n_lrec.cls = r_cls;
                    n_crec.cls = r_cls;
                    n_lrec.tot = NW'(1) << (EMPTY - r_cls);
                    n_crec.tot = NW'(1) << (EMPTY - r_cls);
                    n_lrec.fr  = (NW'(1) << (EMPTY - r_cls)) - NW'(1);
                    n_crec.fr  = (NW'(1) << (EMPTY - r_cls)) - NW'(1);
                    n_lrec.bits[0] = 1'b1;
                    n_crec.bits[0] = 1'b1;
                    n_map[r_cls][r_unit] = 1'b1;
                    n_map[G][r_unit]     = 1'b0;
                    lwe = 1'b1;
                    cwe = 1'b1;
                end else if (lrec.cls == r_cls && lrec.fr != '0 && ffs_s.found) begin
                    abit       = G'(ffs_s.idx);
                    n_lrec.fr  = lrec.fr - NW'(1);
                    n_crec.fr  = crec.fr - NW'(1);
                    n_lrec.bits[abit] = 1'b1;
                    n_crec.bits[abit] = 1'b1;
                    if (n_lrec.fr == '0) begin
                        n_map[r_cls][r_unit] = 1'b0;
                    end
                    lwe = 1'b1;
                    cwe = 1'b1;
                end else begin
                    sts = scba_pkg::STS_NO_SPACE;
                end
                if (sts == scba_pkg::STS_OK) begin
                    raddr = (AW'(r_unit) << G) + (AW'(abit) << r_cls);
                end
            end
            scba_pkg::OP_FREE, scba_pkg::OP_RELEASE: begin
                if (!r_inrange || !frec.bits[fbit]) begin
                    sts = scba_pkg::STS_NOT_ALLOC;
                end else begin
                    frec.bits[fbit] = 1'b0;
                    frec.fr         = ffr;
                    if (ffr == frec.tot) begin
                        // last slot gone: unit back to empty
                        if (lock_side) begin
                            n_map[fc][r_unit] = 1'b0;
                            n_map[G][r_unit]  = 1'b1;
                        end
                        frec.cls = EMPTY;
                        frec.fr  = NW'(1);
                        frec.tot = NW'(1);
                    end else if (lock_side && ffr == NW'(1)) begin
                        n_map[fc][r_unit] = 1'b1;
                    end
                    if (lock_side) begin
                        n_lrec = frec;
                        lwe    = 1'b1;
                    end else begin
                        n_crec = frec;
                        cwe    = 1'b1;
                    end
                end
            end
            scba_pkg::OP_QSIZE: begin
                qsize = r_inrange ? 3'(crec.cls) : 3'(G);
            end
            scba_pkg::OP_QALLOC: begin
                qalloc = r_inrange && crec.bits[r_addr[G-1:0] >> qc];
            end
            default: begin
            end
        endcase
    end

    // sequencer, map bits and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_rsp_valid <= 1'b0;
            for (int m = 0; m <= G; m++) begin
                r_map[m] <= (m == G) ? '1 : '0;
            end
        end else begin
            // a new response word replaces the one taken at this edge
            if (go) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + UW'(1);
                    if (r_clr == UW'(NUM_UNITS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (acc) begin
                        r_state   <= ST_EXEC;
                        r_op      <= scba_pkg::t_op'(i_req.opcode);
                        r_cls     <= c_in;
                        r_addr    <= i_req.block_addr;
                        r_unit    <= rd_unit;
                        r_found   <= ffs_c.found || ffs_e.found;
                        r_inrange <= (unit_full < AW'(NUM_UNITS));
                    end
                end
                ST_EXEC: begin
                    if (go) begin
                        r_state     <= ST_IDLE;
                        r_map       <= n_map;
                        r_sts       <= sts;
                        r_raddr     <= raddr;
                        r_qsize     <= qsize;
                        r_qalloc    <= qalloc;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.status          = r_sts;
    assign o_rsp.result_addr     = r_raddr;
    assign o_rsp.block_size_log2 = r_qsize;
    assign o_rsp.is_allocated    = r_qalloc;

    // checks
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !i_req.ready)
        else $error("request taken during clearing pass");
    a_acc_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_state == ST_EXEC)
        else $error("accepted word not executed");
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state) == ST_EXEC)
        else $error("response word without an executed request");
endmodule

// File: test/scba_checker.sv
module scba_checker #(
    parameter int unsigned NUM_UNITS        = 64,
    parameter int unsigned UNIT_GRAINS_LOG2 = 6
) (
    input  logic i_clk,
    input  logic i_rst_n,
    scba_req_if.sink   i_req,
    scba_rsp_if.sink   i_rsp,
    output int unsigned o_errors,
    output int unsigned o_pending,
    output int unsigned o_responses
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS    = 1 << UNIT_GRAINS_LOG2;
    localparam int unsigned EMPTY    = UNIT_GRAINS_LOG2;
    localparam int unsigned CNT_W    = UNIT_GRAINS_LOG2 + 1;

    typedef struct packed {
        logic [1:0]                  status;
        logic [scba_pkg::ADDR_W-1:0] addr;
        logic [2:0]                  qsize;
        logic                        qalloc;
    } t_rsp;

    // model of the allocator state: lock side and committed side
    typedef struct {
        logic [SLOTS-1:0] bits;
        int unsigned      cls;
        logic [CNT_W-1:0] nfree;
        logic [CNT_W-1:0] total;
    } t_unit;

    t_unit             lock_rec   [NUM_UNITS];
    t_unit             commit_rec [NUM_UNITS];
    logic [NUM_UNITS-1:0] avail_map [EMPTY+1];
    t_rsp              rsp_queue [$];

    function automatic int unsigned first_unit(logic [NUM_UNITS-1:0] m);
        for (int unsigned i = 0; i < NUM_UNITS; i++)
            if (m[i]) return i;
        return NUM_UNITS;
    endfunction

    task automatic clear_state();
        for (int unsigned u = 0; u < NUM_UNITS; u++) begin
            lock_rec[u]   = '{bits: '0, cls: EMPTY, nfree: CNT_W'(1), total: CNT_W'(1)};
            commit_rec[u] = '{bits: '0, cls: EMPTY, nfree: CNT_W'(1), total: CNT_W'(1)};
        end
        for (int unsigned c = 0; c <= EMPTY; c++) avail_map[c] = '0;
        avail_map[EMPTY] = '1;
    endtask

    function automatic logic [1:0] allocate(input int unsigned size,
                                            output logic [scba_pkg::ADDR_W-1:0] addr);
        int unsigned c, u, b, lim, n;
        c = (size > EMPTY) ? EMPTY : size;
        addr = '0;
        u = first_unit(avail_map[c]);
        if (u >= NUM_UNITS) u = first_unit(avail_map[EMPTY]);
        if (u >= NUM_UNITS) return scba_pkg::STS_NO_SPACE;
        if (lock_rec[u].cls == EMPTY && lock_rec[u].nfree != 0) begin
            n = 1 << (EMPTY - c);
            lock_rec[u].cls = c;
            commit_rec[u].cls = c;
            lock_rec[u].total = CNT_W'(n);
            commit_rec[u].total = CNT_W'(n);
            lock_rec[u].nfree = CNT_W'(n - 1);
            commit_rec[u].nfree = CNT_W'(n - 1);
            avail_map[c][u] = 1'b1;
            avail_map[EMPTY][u] = 1'b0;
            b = 0;
        end else if (lock_rec[u].cls == c && lock_rec[u].nfree != 0) begin
            lim = (lock_rec[u].total > SLOTS) ? SLOTS : lock_rec[u].total;
            for (b = 0; b < lim; b++)
                if (!lock_rec[u].bits[b]) break;
            if (b >= lim) return scba_pkg::STS_NO_SPACE;
            lock_rec[u].nfree = lock_rec[u].nfree - CNT_W'(1);
            commit_rec[u].nfree = commit_rec[u].nfree - CNT_W'(1);
            if (lock_rec[u].nfree == 0) avail_map[c][u] = 1'b0;
        end else begin
            return scba_pkg::STS_NO_SPACE;
        end
        lock_rec[u].bits[b] = 1'b1;
        commit_rec[u].bits[b] = 1'b1;
        addr = scba_pkg::ADDR_W'((u << UNIT_GRAINS_LOG2) + (b << c));
        return scba_pkg::STS_OK;
    endfunction

    function automatic logic [1:0] free_slot(int unsigned addr, bit lock_side);
        int unsigned u, c, b;
        t_unit r;
        u = addr >> UNIT_GRAINS_LOG2;
        if (u >= NUM_UNITS) return scba_pkg::STS_NOT_ALLOC;
        r = lock_side ? lock_rec[u] : commit_rec[u];
        c = (r.cls > EMPTY) ? EMPTY : r.cls;
        b = (addr % SLOTS) >> c;
        if (!r.bits[b]) return scba_pkg::STS_NOT_ALLOC;
        r.bits[b] = 1'b0;
        r.nfree = r.nfree + CNT_W'(1);
        if (r.nfree == r.total) begin
            if (lock_side) avail_map[c][u] = 1'b0;
            r.cls = EMPTY;
            r.nfree = CNT_W'(1);
            r.total = CNT_W'(1);
            if (lock_side) avail_map[EMPTY][u] = 1'b1;
        end else if (lock_side && r.nfree == 1) begin
            avail_map[c][u] = 1'b1;
        end
        if (lock_side) lock_rec[u] = r;
        else commit_rec[u] = r;
        return scba_pkg::STS_OK;
    endfunction

    function automatic t_rsp predict_response(logic [2:0] op, logic [2:0] size,
                                              logic [scba_pkg::ADDR_W-1:0] addr);
        t_rsp r;
        int unsigned u, c;
        r = '0;
        u = addr >> UNIT_GRAINS_LOG2;
        case (op)
            scba_pkg::OP_ALLOC: r.status = allocate(size, r.addr);
            scba_pkg::OP_FREE: r.status = free_slot(addr, 1'b0);
            scba_pkg::OP_RELEASE: r.status = free_slot(addr, 1'b1);
            scba_pkg::OP_QSIZE:
                r.qsize = (u < NUM_UNITS) ? 3'(commit_rec[u].cls) : 3'(EMPTY);
            scba_pkg::OP_QALLOC: begin
                if (u < NUM_UNITS) begin
                    c = (commit_rec[u].cls > EMPTY) ? EMPTY : commit_rec[u].cls;
                    r.qalloc = commit_rec[u].bits[(addr % SLOTS) >> c];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, int unsigned got, int unsigned want);
        o_errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    initial begin
        o_errors = 0;
        o_responses = 0;
        clear_state();
    end

    // sample both channels at the clock edge
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready)
                rsp_queue.push_back(predict_response(i_req.opcode, i_req.size_log2,
                                                     i_req.block_addr));
            if (i_rsp.valid && i_rsp.ready) begin
                o_responses++;
                if (rsp_queue.size() == 0) begin
                    o_errors++;
                    $display("[%0t] response word with nothing expected", $realtime);
                end else begin
                    want = rsp_queue.pop_front();
                    if (i_rsp.status !== want.status)
                        report("status", i_rsp.status, want.status);
                    if (i_rsp.result_addr !== want.addr)
                        report("result_addr", i_rsp.result_addr, want.addr);
                    if (i_rsp.block_size_log2 !== want.qsize)
                        report("block_size_log2", i_rsp.block_size_log2, want.qsize);
                    if (i_rsp.is_allocated !== want.qalloc)
                        report("is_allocated", i_rsp.is_allocated, want.qalloc);
                end
            end
        end
        o_pending = rsp_queue.size();
    end
endmodule

// File: test/tb_size_class_bitmap_allocator.sv
module tb_size_class_bitmap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    int unsigned err_count, pending, rsp_count;
    int unsigned n_words;
    bit calm;
    logic [scba_pkg::ADDR_W-1:0] granted [$];

    scba_req_if req_ch ();
    scba_rsp_if rsp_ch ();

    size_class_bitmap_allocator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    scba_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .i_rsp      (rsp_ch.sink),
        .o_errors   (err_count),
        .o_pending  (pending),
        .o_responses(rsp_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // limit on run time
    initial begin
        #3ms;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

    // response side stalls in random bursts
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // remember granted block addresses for later frees
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == scba_pkg::STS_OK
            && rsp_ch.result_addr != '0) begin
            if (granted.size() >= 200) void'(granted.pop_front());
            granted.push_back(rsp_ch.result_addr);
        end
    end

    // send one request word, with an optional gap before it
    task automatic send_word(logic [2:0] op, logic [2:0] size,
                             logic [scba_pkg::ADDR_W-1:0] addr);
        if (!calm && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.size_log2  <= size;
        req_ch.block_addr <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
        n_words++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // random address: mostly a granted block, sometimes anything
    function automatic logic [scba_pkg::ADDR_W-1:0] pick_addr();
        if (granted.size() != 0 && $urandom_range(0, 3) != 0)
            return granted[$urandom_range(0, granted.size() - 1)];
        return scba_pkg::ADDR_W'($urandom);
    endfunction

    initial begin
        logic [2:0] op;
        logic [scba_pkg::ADDR_W-1:0] a;
        n_words = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.opcode = '0;
        req_ch.size_log2 = '0;
        req_ch.block_addr = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every size, oversize, frees, double free, queries, far units, undefined opcodes
        for (int s = 0; s < 8; s++) send_word(scba_pkg::OP_ALLOC, 3'(s), '0);
        send_word(scba_pkg::OP_QSIZE, '0, 12'd0);
        send_word(scba_pkg::OP_QALLOC, '0, 12'd1);
        send_word(scba_pkg::OP_QALLOC, '0, 12'd0);
        send_word(scba_pkg::OP_FREE, '0, 12'd0);
        send_word(scba_pkg::OP_FREE, '0, 12'd0);
        send_word(scba_pkg::OP_RELEASE, '0, 12'd0);
        send_word(scba_pkg::OP_RELEASE, '0, 12'd0);
        send_word(scba_pkg::OP_QSIZE, '0, 12'hFFF);
        send_word(scba_pkg::OP_QALLOC, '0, 12'hFFF);
        send_word(scba_pkg::OP_FREE, '0, 12'hFFF);
        send_word(scba_pkg::OP_RELEASE, '0, 12'hFC0);
        send_word(3'd5, 3'd7, 12'hAAA);
        send_word(3'd7, 3'd0, 12'h555);
        drain();

        // random: allocate-heavy, frees aimed at granted blocks
        for (int i = 0; i < 700; i++) begin
            if (i == 600) calm = 1'b1;
            if (i == 300) drain();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = scba_pkg::OP_ALLOC;
                4, 5: op = scba_pkg::OP_FREE;
                6, 7: op = scba_pkg::OP_RELEASE;
                8: op = $urandom_range(0, 1) ? scba_pkg::OP_QSIZE : scba_pkg::OP_QALLOC;
                default: op = 3'($urandom_range(0, 7));
            endcase
            a = pick_addr();
            send_word(op, 3'($urandom_range(0, 7)), a);
        end
        drain();
        repeat (20) @(posedge i_clk);
        $display("%0d request words sent, %0d responses checked", n_words, rsp_count);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/scba_pkg.sv
rtl/scba_if.sv
rtl/scba_ffs.sv
rtl/scba_ram.sv
rtl/size_class_bitmap_allocator.sv
test/scba_checker.sv
test/tb_size_class_bitmap_allocator.sv
